### rtl/tmgl_pkg.sv
package tmgl_pkg;

  // Parse phases of the markup scanner
  localparam logic [2:0] PH_TEXT   = 3'd0;
  localparam logic [2:0] PH_DOLLAR = 3'd1;
  localparam logic [2:0] PH_COLOR  = 3'd2;
  localparam logic [2:0] PH_HIGH   = 3'd3;
  localparam logic [2:0] PH_BLINK  = 3'd4;
  localparam logic [2:0] PH_FONT   = 3'd5;
  localparam logic [2:0] PH_SKIP   = 3'd6;

  // Register offsets within one font's block of four
  localparam logic [1:0] REG_ADV_X  = 2'd0;
  localparam logic [1:0] REG_ADV_Y  = 2'd1;
  localparam logic [1:0] REG_TILE_W = 2'd2;
  localparam logic [1:0] REG_TILE_H = 2'd3;

  localparam int CFG_IDX_W = 4;

  // Byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_H      = 8'h48;

  // Per-string reset value and accepted digit limits
  localparam logic [3:0] COLOR_INIT = 4'd7;
  localparam logic [7:0] MAX_COLOR  = 8'd9;
  localparam logic [7:0] MAX_HIGH   = 8'd2;
  localparam logic [7:0] MAX_BLINK  = 8'd2;

  localparam logic [1:0] BLINK_NONE = 2'd0;
  localparam logic [1:0] BLINK_SLOW = 2'd1;
  localparam logic [1:0] BLINK_FAST = 2'd2;

  typedef struct packed {
    logic [7:0] adv_x;
    logic [7:0] adv_y;
    logic [6:0] tile_w;
    logic [6:0] tile_h;
  } tmgl_font_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [7:0]  layer;
    logic        measure_only;
    logic [15:0] time_tick;
  } tmgl_in_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [9:0]  tex_u;
    logic [9:0]  tex_v;
    logic [5:0]  size_w;
    logic [5:0]  size_h;
    logic [3:0]  color_index;
    logic [1:0]  highlight;
    logic        font_select;
    logic [7:0]  draw_layer;
  } tmgl_out_t;

endpackage

### rtl/tmgl_cfg.sv
module tmgl_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wr_en,
  input  logic [tmgl_pkg::CFG_IDX_W-1:0]        wr_index,
  input  logic [7:0]                            wr_data,
  output tmgl_pkg::tmgl_font_t [1:0]            fonts
);
  import tmgl_pkg::*;

  tmgl_font_t [1:0] fonts_r;
  logic             sel;

  assign sel   = wr_index[2];
  assign fonts = fonts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        fonts_r[i].adv_x  <= 8'd6;
        fonts_r[i].adv_y  <= 8'd12;
        fonts_r[i].tile_w <= 7'd8;
        fonts_r[i].tile_h <= 7'd16;
      end
    end else if (wr_en && !wr_index[CFG_IDX_W-1]) begin
      unique case (wr_index[1:0])
        REG_ADV_X:  fonts_r[sel].adv_x  <= wr_data;
        REG_ADV_Y:  fonts_r[sel].adv_y  <= wr_data;
        REG_TILE_W: fonts_r[sel].tile_w <= wr_data[6:0];
        REG_TILE_H: fonts_r[sel].tile_h <= wr_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/tmgl_core.sv
module tmgl_core #(
  parameter int TAB_COLUMNS = 4,
  parameter int FONT_COUNT  = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  tmgl_pkg::tmgl_in_t         item,
  input  tmgl_pkg::tmgl_font_t [1:0] fonts,
  output logic                       res_valid,
  output tmgl_pkg::tmgl_out_t        res
);
  import tmgl_pkg::*;

  localparam int MW = (TAB_COLUMNS > 1) ? $clog2(TAB_COLUMNS) : 1;
  localparam logic [16:0] TAB_STEP = 17'(TAB_COLUMNS);
  localparam logic [MW-1:0] MOD_LAST = MW'(TAB_COLUMNS - 1);
  // tab phase of a column that wrapped past 16 bits on a tab
  localparam logic [MW-1:0] WRAP_MOD =
    MW'((TAB_COLUMNS - (65536 % TAB_COLUMNS)) % TAB_COLUMNS);
  localparam logic [7:0] FONT_LIMIT = 8'((FONT_COUNT < 2) ? FONT_COUNT : 2);

  logic [2:0]    phase_r, phase_nxt;
  logic [15:0]   cx_r, cx_nxt;
  logic [15:0]   cy_r, cy_nxt;
  logic [15:0]   col_r, col_nxt;
  logic [MW-1:0] mod_r, mod_nxt;
  logic [15:0]   wide_r, wide_nxt;
  logic [3:0]    color_r, color_nxt;
  logic [1:0]    high_r, high_nxt;
  logic [1:0]    blink_r, blink_nxt;
  logic          font_r, font_nxt;

  logic [7:0]  c;
  logic [7:0]  d;
  logic        is_text;
  logic        show;
  tmgl_font_t  fa;
  logic [15:0] wide_take;
  logic [16:0] tab_sum;
  logic [23:0] tab_prod;
  logic [10:0] u_prod;
  logic [10:0] v_prod;

  assign c  = item.char_code;
  assign d  = c - CH_ZERO;
  assign fa = fonts[font_r];

  assign wide_take = ($signed(cx_r) > $signed(wide_r)) ? cx_r : wide_r;
  assign tab_sum   = {1'b0, col_r} + (TAB_STEP - 17'(mod_r));
  assign tab_prod  = tab_sum[15:0] * fa.adv_x;
  assign u_prod    = {7'b0, c[3:0]} * {4'b0, fa.tile_w};
  assign v_prod    = {7'b0, c[7:4]} * {4'b0, fa.tile_h};

  always_comb begin
    unique case (blink_r)
      BLINK_SLOW: show = item.time_tick[3];
      BLINK_FAST: show = item.time_tick[5];
      default:    show = 1'b1;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    col_nxt   = col_r;
    mod_nxt   = mod_r;
    wide_nxt  = wide_r;
    color_nxt = color_r;
    high_nxt  = high_r;
    blink_nxt = blink_r;
    font_nxt  = font_r;
    is_text   = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (c == CH_NUL) begin
      // end of string: report widest line, restore per-string state
      res_valid = 1'b1;
      res.kind  = 1'b1;
      res.pos_x = wide_take;
      phase_nxt = PH_TEXT;
      cx_nxt    = '0;
      cy_nxt    = '0;
      col_nxt   = '0;
      mod_nxt   = '0;
      wide_nxt  = '0;
      color_nxt = COLOR_INIT;
      high_nxt  = '0;
      blink_nxt = BLINK_NONE;
      font_nxt  = 1'b0;
    end else begin
      phase_nxt = PH_TEXT;
      unique case (phase_r)
        PH_DOLLAR: begin
          case (c)
            CH_C:    phase_nxt = PH_COLOR;
            CH_H:    phase_nxt = PH_HIGH;
            CH_B:    phase_nxt = PH_BLINK;
            CH_F:    phase_nxt = PH_FONT;
            CH_A:    phase_nxt = PH_SKIP;
            CH_E:    phase_nxt = PH_TEXT;
            default: is_text = 1'b1;
          endcase
        end
        PH_COLOR: if (d <= MAX_COLOR) color_nxt = d[3:0];
        PH_HIGH:  if (d <= MAX_HIGH)  high_nxt  = d[1:0];
        PH_BLINK: if (d <= MAX_BLINK) blink_nxt = d[1:0];
        PH_FONT:  if (d < FONT_LIMIT) font_nxt  = d[0];
        PH_SKIP:  if (c != CH_DOLLAR) phase_nxt = PH_SKIP;
        default:  is_text = 1'b1;
      endcase

      if (is_text) begin
        if (c == CH_LF) begin
          wide_nxt = wide_take;
          cx_nxt   = '0;
          col_nxt  = '0;
          mod_nxt  = '0;
          cy_nxt   = cy_r + {8'b0, fa.adv_y};
        end else if (c == CH_TAB) begin
          col_nxt = tab_sum[15:0];
          mod_nxt = tab_sum[16] ? WRAP_MOD : '0;
          cx_nxt  = tab_prod[15:0];
        end else if (c == CH_DOLLAR) begin
          phase_nxt = PH_DOLLAR;
        end else begin
          if (show && !item.measure_only) begin
            res_valid       = 1'b1;
            res.pos_x       = item.origin_x + cx_r;
            res.pos_y       = item.origin_y + cy_r;
            res.tex_u       = u_prod[9:0];
            res.tex_v       = v_prod[9:0];
            res.size_w      = 6'(fa.tile_w - 7'd1);
            res.size_h      = 6'(fa.tile_h - 7'd1);
            res.color_index = color_r;
            res.highlight   = high_r;
            res.font_select = font_r;
            res.draw_layer  = item.layer;
          end
          cx_nxt  = cx_r + {8'b0, fa.adv_x};
          col_nxt = col_r + 16'd1;
          if (col_r == 16'hffff || mod_r == MOD_LAST) mod_nxt = '0;
          else mod_nxt = mod_r + MW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      cx_r    <= '0;
      cy_r    <= '0;
      col_r   <= '0;
      mod_r   <= '0;
      wide_r  <= '0;
      color_r <= COLOR_INIT;
      high_r  <= '0;
      blink_r <= BLINK_NONE;
      font_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      col_r   <= col_nxt;
      mod_r   <= mod_nxt;
      wide_r  <= wide_nxt;
      color_r <= color_nxt;
      high_r  <= high_nxt;
      blink_r <= blink_nxt;
      font_r  <= font_nxt;
    end
  end

endmodule

### rtl/text_markup_glyph_layout_top.sv
// A request is captured in the input register, then passes through the layout
// logic into the result register. Throughput: one byte per cycle unless
// out_stall holds a pending result; the pen and parse state update in one pass
// through the layout logic, so each byte sees the state the previous one left.
// Reset (rst_n low, synchronous) restores the font registers to their defaults
// and the per-string state to the start of a new string; the input and
// output registers come up empty.
module text_markup_glyph_layout_top #(
  parameter int TAB_COLUMNS = 4,
  parameter int FONT_COUNT  = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // byte requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_char_code,
  input  logic signed [15:0]              in_origin_x,
  input  logic signed [15:0]              in_origin_y,
  input  logic [7:0]                      in_layer,
  input  logic                            in_measure_only,
  input  logic [15:0]                     in_time_tick,
  // glyph and width results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_kind,
  output logic signed [15:0]              out_pos_x,
  output logic signed [15:0]              out_pos_y,
  output logic [9:0]                      out_tex_u,
  output logic [9:0]                      out_tex_v,
  output logic [5:0]                      out_size_w,
  output logic [5:0]                      out_size_h,
  output logic [3:0]                      out_color_index,
  output logic [1:0]                      out_highlight,
  output logic                            out_font_select,
  output logic [7:0]                      out_draw_layer,
  // font register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tmgl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data
);
  import tmgl_pkg::*;

  tmgl_font_t [1:0] fonts;
  tmgl_in_t         in_r;
  logic             in_vld_r;
  tmgl_out_t        out_r;
  logic             out_vld_r;
  logic             fire;
  logic             res_valid;
  tmgl_out_t        res;

  // Register writes take effect in the cycle after they are offered; never hold off a write.
  assign cfg_ready = 1'b1;

  tmgl_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .fonts    (fonts)
  );

  // Advance the held byte whenever the result register is free or draining.
  // Bytes that give no result wait too, which keeps the order simple.
  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  // Capture the request payload; no reset needed on data.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r.char_code    <= in_char_code;
      in_r.origin_x     <= in_origin_x;
      in_r.origin_y     <= in_origin_y;
      in_r.layer        <= in_layer;
      in_r.measure_only <= in_measure_only;
      in_r.time_tick    <= in_time_tick;
    end
  end

  tmgl_core #(
    .TAB_COLUMNS (TAB_COLUMNS),
    .FONT_COUNT  (FONT_COUNT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_r),
    .fonts     (fonts),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: load on every advance, drop when taken with nothing new.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= res_valid;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_kind        = out_r.kind;
  assign out_pos_x       = out_r.pos_x;
  assign out_pos_y       = out_r.pos_y;
  assign out_tex_u       = out_r.tex_u;
  assign out_tex_v       = out_r.tex_v;
  assign out_size_w      = out_r.size_w;
  assign out_size_h      = out_r.size_h;
  assign out_color_index = out_r.color_index;
  assign out_highlight   = out_r.highlight;
  assign out_font_select = out_r.font_select;
  assign out_draw_layer  = out_r.draw_layer;

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

// Testbench for the text markup glyph layout block.
// Streams text bytes (plain text, tabs, newlines, every markup escape, broken
// and truncated escapes) through the byte channel while the font registers move
// through several settings. A shadow model of the layout state predicts each
// glyph placement and end-of-string width report. A checker compares each
// result, field by field, against the oldest prediction.
module tb;
  import tmgl_pkg::*;

  localparam int TAB_COLS     = 4;
  localparam int FONTS        = 2;
  localparam int CLK_HALF     = 6;
  localparam int MAX_BURST    = 18;
  // Leave margin after the last result before a register write.
  localparam int DRAIN_CYCLES = 8;
  localparam logic [3:0] CFG_LAST = 4'd7;
  localparam logic [63:0] FONT_DEFAULTS = 64'h10080C06_10080C06;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_code    = '0;
  logic signed [15:0] in_origin_x     = '0;
  logic signed [15:0] in_origin_y     = '0;
  logic [7:0]         in_layer        = '0;
  logic               in_measure_only = 1'b0;
  logic [15:0]        in_time_tick    = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_kind;
  logic signed [15:0] out_pos_x;
  logic signed [15:0] out_pos_y;
  logic [9:0]         out_tex_u;
  logic [9:0]         out_tex_v;
  logic [5:0]         out_size_w;
  logic [5:0]         out_size_h;
  logic [3:0]         out_color_index;
  logic [1:0]         out_highlight;
  logic               out_font_select;
  logic [7:0]         out_draw_layer;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;

  // Shadow copy of the font registers and the per-string layout state
  tmgl_font_t  font_regs [2];
  logic        at_start;
  logic [2:0]  scan_phase;
  logic [15:0] pen_x, pen_y, column, widest;
  logic [3:0]  pen_color;
  logic [1:0]  pen_highlight, pen_blink;
  logic        pen_font;

  tmgl_out_t expected_placements [$];

  // Fields shared by the bytes of the string being sent
  tmgl_in_t text_ctx;
  logic     hold_ctx = 1'b0;

  int errors       = 0;
  int bytes_sent   = 0;
  int glyphs_seen  = 0;
  int widths_seen  = 0;
  int in_gap_pct   = 0;
  int out_gap_pct  = 0;
  int stall_left   = 0;

  text_markup_glyph_layout_top #(
    .TAB_COLUMNS (TAB_COLS),
    .FONT_COUNT  (FONTS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_layer        (in_layer),
    .in_measure_only (in_measure_only),
    .in_time_tick    (in_time_tick),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_size_w      (out_size_w),
    .out_size_h      (out_size_h),
    .out_color_index (out_color_index),
    .out_highlight   (out_highlight),
    .out_font_select (out_font_select),
    .out_draw_layer  (out_draw_layer),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Layout prediction
  // ---------------------------------------------------------------------------

  // Put the pen, escape parser and text attributes back to a fresh string.
  function automatic void restart_string();
    scan_phase    = PH_TEXT;
    pen_x         = '0;
    pen_y         = '0;
    column        = '0;
    widest        = '0;
    pen_color     = COLOR_INIT;
    pen_highlight = '0;
    pen_blink     = BLINK_NONE;
    pen_font      = 1'b0;
  endfunction

  // Line widths compare as signed 16-bit values.
  function automatic void note_line_width();
    if ($signed(widest) < $signed(pen_x)) widest = pen_x;
  endfunction

  // Ordinary text: newline, tab, start of escape, or a printable glyph.
  function automatic void print_byte(tmgl_in_t req);
    tmgl_font_t fr;
    tmgl_out_t  g;
    logic       shown;
    int         tabbed;
    fr = font_regs[pen_font];
    if (req.char_code == CH_LF) begin
      note_line_width();
      pen_x  = '0;
      column = '0;
      pen_y  = pen_y + 16'(fr.adv_y);
    end else if (req.char_code == CH_TAB) begin
      tabbed = (int'(column) + TAB_COLS) / TAB_COLS * TAB_COLS;
      column = 16'(tabbed);
      pen_x  = 16'(int'(column) * int'(fr.adv_x));
    end else if (req.char_code == CH_DOLLAR) begin
      scan_phase = PH_DOLLAR;
    end else begin
      case (pen_blink)
        BLINK_SLOW: shown = req.time_tick[3];
        BLINK_FAST: shown = req.time_tick[5];
        default:    shown = 1'b1;
      endcase
      if (shown && !req.measure_only) begin
        g             = '0;
        g.kind        = 1'b0;
        g.pos_x       = req.origin_x + pen_x;
        g.pos_y       = req.origin_y + pen_y;
        g.tex_u       = 10'(int'(req.char_code[3:0]) * int'(fr.tile_w));
        g.tex_v       = 10'(int'(req.char_code[7:4]) * int'(fr.tile_h));
        g.size_w      = 6'(fr.tile_w - 7'd1);
        g.size_h      = 6'(fr.tile_h - 7'd1);
        g.color_index = pen_color;
        g.highlight   = pen_highlight;
        g.font_select = pen_font;
        g.draw_layer  = req.layer;
        expected_placements.push_back(g);
      end
      // Hidden glyphs still advance the pen.
      pen_x  = pen_x + 16'(fr.adv_x);
      column = column + 16'd1;
    end
  endfunction

  // Advance the shadow state by one accepted byte request.
  function automatic void layout_byte(tmgl_in_t req);
    logic [7:0] digit;
    logic [2:0] was;
    tmgl_out_t  w;
    digit = req.char_code - CH_ZERO;
    if (at_start) begin
      restart_string();
      at_start = 1'b0;
    end
    if (req.char_code == CH_NUL) begin
      // End of string, even in the middle of an escape
      note_line_width();
      w       = '0;
      w.kind  = 1'b1;
      w.pos_x = widest;
      expected_placements.push_back(w);
      restart_string();
      at_start = 1'b1;
    end else begin
      was        = scan_phase;
      scan_phase = PH_TEXT;
      case (was)
        PH_DOLLAR: begin
          case (req.char_code)
            CH_C:    scan_phase = PH_COLOR;
            CH_H:    scan_phase = PH_HIGH;
            CH_B:    scan_phase = PH_BLINK;
            CH_F:    scan_phase = PH_FONT;
            CH_A:    scan_phase = PH_SKIP;
            CH_E:    ;  // consumed, no effect
            default: print_byte(req);  // drop the '$', keep the byte as text
          endcase
        end
        PH_COLOR: if (digit <= MAX_COLOR) pen_color = digit[3:0];
        PH_HIGH:  if (digit <= MAX_HIGH) pen_highlight = digit[1:0];
        PH_BLINK: if (digit <= MAX_BLINK) pen_blink = digit[1:0];
        PH_FONT:  if (digit < FONTS) pen_font = digit[0];
        PH_SKIP:  if (req.char_code != CH_DOLLAR) scan_phase = PH_SKIP;
        default:  print_byte(req);
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (rst_n && out_gap_pct > 0 && $urandom_range(99) < out_gap_pct) begin
      stall_left = $urandom_range(MAX_BURST, 1);
    end
    out_stall <= (stall_left > 0);
  end

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    tmgl_out_t got;
    tmgl_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_kind, out_pos_x, out_pos_y, out_tex_u, out_tex_v, out_size_w,
             out_size_h, out_color_index, out_highlight, out_font_select, out_draw_layer};
      if (expected_placements.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d pos_x %0d pos_y %0d",
                 $time, got.kind, got.pos_x, got.pos_y);
      end else begin
        want = expected_placements.pop_front();
        compare_field("kind", want.kind, got.kind);
        compare_field("pos_x", want.pos_x, got.pos_x);
        compare_field("pos_y", want.pos_y, got.pos_y);
        compare_field("tex_u", want.tex_u, got.tex_u);
        compare_field("tex_v", want.tex_v, got.tex_v);
        compare_field("size_w", want.size_w, got.size_w);
        compare_field("size_h", want.size_h, got.size_h);
        compare_field("color_index", want.color_index, got.color_index);
        compare_field("highlight", want.highlight, got.highlight);
        compare_field("font_select", want.font_select, got.font_select);
        compare_field("draw_layer", want.draw_layer, got.draw_layer);
        if (want.kind) widths_seen++;
        else glyphs_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Drive one byte request and hold it until accepted. Leave valid high so a
  // following request goes out back to back.
  task automatic send_byte(input tmgl_in_t req);
    if (in_gap_pct > 0 && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(MAX_BURST, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_char_code    <= req.char_code;
    in_origin_x     <= req.origin_x;
    in_origin_y     <= req.origin_y;
    in_layer        <= req.layer;
    in_measure_only <= req.measure_only;
    in_time_tick    <= req.time_tick;
    do @(posedge clk); while (in_stall);
    layout_byte(req);
    bytes_sent++;
  endtask

  // Send one byte of the current string; layer and tick churn per byte
  // unless the caller pins them.
  task automatic send_char(input logic [7:0] c);
    tmgl_in_t req;
    if (!hold_ctx) begin
      text_ctx.layer     = 8'($urandom);
      text_ctx.time_tick = 16'($urandom);
    end
    req           = text_ctx;
    req.char_code = c;
    send_byte(req);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop valid, wait out every prediction plus the pipeline tail.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all eight font registers (byte i of vals to index i), then one
  // write to an index past the last register, which must change nothing.
  task automatic program_fonts(input logic [63:0] vals);
    for (int i = 0; i <= CFG_LAST + 1; i++) begin
      cfg_valid <= 1'b1;
      if (i <= CFG_LAST) begin
        cfg_index <= 4'(i);
        cfg_data  <= vals[8*i +: 8];
      end else begin
        cfg_index <= 4'($urandom_range(2**CFG_IDX_W - 1, CFG_LAST + 1));
        cfg_data  <= 8'($urandom);
      end
      do @(posedge clk); while (!cfg_ready);
      if (cfg_index <= CFG_LAST) begin
        case (cfg_index[1:0])
          REG_ADV_X:  font_regs[cfg_index[2]].adv_x  = cfg_data;
          REG_ADV_Y:  font_regs[cfg_index[2]].adv_y  = cfg_data;
          REG_TILE_W: font_regs[cfg_index[2]].tile_w = cfg_data[6:0];
          default:    font_regs[cfg_index[2]].tile_h = cfg_data[6:0];
        endcase
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // One string of random content, mostly well-formed markup, ended by NUL.
  task automatic send_random_string(input int len);
    int pick;
    text_ctx.origin_x     = 16'($urandom);
    text_ctx.origin_y     = 16'($urandom);
    text_ctx.measure_only = ($urandom_range(99) < 15);
    for (int n = 0; n < len; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_char(8'($urandom_range(8'h7e, 8'h20)));
      end else if (pick < 52) begin
        send_char(CH_TAB);
      end else if (pick < 60) begin
        send_char(CH_LF);
      end else if (pick < 80) begin
        // attribute escape; mostly a digit, sometimes any byte
        send_char(CH_DOLLAR);
        case ($urandom_range(3))
          0:       send_char(CH_C);
          1:       send_char(CH_H);
          2:       send_char(CH_B);
          default: send_char(CH_F);
        endcase
        if ($urandom_range(99) < 80) send_char(CH_ZERO + 8'($urandom_range(9)));
        else send_char(8'($urandom_range(255, 1)));
      end else if (pick < 85) begin
        send_char(CH_DOLLAR);
        send_char(CH_E);
      end else if (pick < 90) begin
        // skip run: text without '$', closed by '$'
        send_char(CH_DOLLAR);
        send_char(CH_A);
        repeat ($urandom_range(4)) send_char(8'($urandom_range(8'h7e, 8'h25)));
        send_char(CH_DOLLAR);
      end else if (pick < 95) begin
        send_char(CH_DOLLAR);
        send_char(8'($urandom_range(255, 1)));
      end else begin
        send_char(8'($urandom_range(255, 1)));
      end
    end
    // Cut some strings off in the middle of an escape.
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_char(CH_DOLLAR);
    end else if (pick < 12) begin
      send_char(CH_DOLLAR);
      send_char(CH_C);
    end
    send_char(CH_NUL);
  endtask

  task automatic run_strings(input int budget);
    int stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) send_random_string($urandom_range(24, 0));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every escape, bad digits, skip, unknown escape byte,
  // blink hiding and NUL inside an escape, all at the reset font settings.
  task automatic test_markup_directed();
    hold_ctx              = 1'b1;
    text_ctx.origin_x     = 16'h7fff;
    text_ctx.origin_y     = 16'h8000;
    text_ctx.layer        = 8'hff;
    text_ctx.measure_only = 1'b0;
    text_ctx.time_tick    = 16'hffff;
    send_char(8'hff);
    send_text("\t$C9x$F1q\n$H7");
    send_char(CH_NUL);
    // Blink on tick bit 3 with the bit clear hides glyphs; '$$' reopens the escape.
    text_ctx.origin_x  = 16'h8000;
    text_ctx.origin_y  = 16'h7fff;
    text_ctx.layer     = 8'h00;
    text_ctx.time_tick = 16'h0020;
    send_text("$B1k$Az$$$EQ$");
    send_char(CH_NUL);
    hold_ctx = 1'b0;
  endtask

  // All-zero and all-ones register settings; with the widest advance a long
  // line wraps the pen past 16 bits.
  task automatic test_register_extremes();
    drain();
    in_gap_pct  = 30;
    out_gap_pct = 30;
    program_fonts(64'h0);
    run_strings(60);
    drain();
    program_fonts({64{1'b1}});
    run_strings(60);
    // steady stretch with no idling on either side
    in_gap_pct  = 0;
    out_gap_pct = 0;
    text_ctx.origin_x     = 16'($urandom);
    text_ctx.origin_y     = 16'($urandom);
    text_ctx.measure_only = 1'b0;
    repeat (260) send_char(8'($urandom_range(8'h7e, 8'h25)));
    send_char(CH_NUL);
  endtask

  // Raw random register bytes, then random values inside the documented ranges.
  task automatic test_random_registers();
    logic [63:0] vals;
    drain();
    in_gap_pct  = 5;
    out_gap_pct = 50;
    program_fonts({$urandom, $urandom});
    run_strings(80);
    drain();
    for (int i = 0; i <= CFG_LAST; i++) begin
      if (i[1]) vals[8*i +: 8] = 8'($urandom_range(64, 1));
      else vals[8*i +: 8] = 8'($urandom_range(255, 0));
    end
    in_gap_pct  = 50;
    out_gap_pct = 5;
    program_fonts(vals);
    run_strings(80);
  endtask

  // Back to the reset settings and a full-rate stream to finish.
  task automatic test_steady_stream();
    drain();
    in_gap_pct  = 0;
    out_gap_pct = 0;
    program_fonts(FONT_DEFAULTS);
    run_strings(90);
  endtask

  initial begin : run
    // shadow state after reset
    for (int f = 0; f < 2; f++) begin
      font_regs[f].adv_x  = FONT_DEFAULTS[7:0];
      font_regs[f].adv_y  = FONT_DEFAULTS[15:8];
      font_regs[f].tile_w = FONT_DEFAULTS[22:16];
      font_regs[f].tile_h = FONT_DEFAULTS[30:24];
    end
    restart_string();
    at_start    = 1'b1;
    text_ctx    = '0;
    in_gap_pct  = 20;
    out_gap_pct = 20;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_markup_directed();
    test_register_extremes();
    test_random_registers();
    test_steady_stream();
    drain();

    if (expected_placements.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_placements.size());
    end
    $display("Sent %0d text bytes across six font register settings.", bytes_sent);
    $display("Checked %0d glyph placements and %0d width reports, %0d mismatches.",
             glyphs_seen, widths_seen, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Far beyond the slowest legal run
  initial begin : watchdog
    #(5_000_000);
    $display("%0t: timeout with %0d results outstanding", $time, expected_placements.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/tmgl_pkg.sv
rtl/tmgl_cfg.sv
rtl/tmgl_core.sv
rtl/text_markup_glyph_layout_top.sv
verif/tb.sv
